/* rtl/rate_monotonic_ready_queue_unit_assert.svh */
// Assertion macros for the rate-monotonic ready queue.
// No dependencies; included by the checker module.
`ifndef RATE_MONOTONIC_READY_QUEUE_UNIT_ASSERT_SVH
`define RATE_MONOTONIC_READY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RMRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmrq assertion failed");

// Next-cycle implication, disabled while in reset.
`define RMRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmrq assertion failed");

`endif

/* rtl/rmrq_pkg.sv */
// Shared types, codes and defaults for the rate-monotonic ready queue.
// No dependencies; imported by every module of the block.
package rmrq_pkg;

    localparam int RMRQ_DEPTH_DEF = 32;
    localparam int QC_W           = 6;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_PICK = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [31:0] period;
    } in_word_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [15:0]     picked_task;
        logic [QC_W-1:0] queued_count;
    } out_word_t;

    typedef struct packed {
        logic [31:0] period;
        logic [15:0] task_id;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ_CMP,
        S_ENQ_PUT,
        S_DEQ_CMP,
        S_PICK_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic       req_load;
        idx_op_t    idx_op;
        logic       rd_en;
        logic       rd_dn;
        logic       wr_en;
        logic       wr_dn;
        logic       wr_new;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       found_clr;
        logic       found_set;
        logic       st_load;
        logic [1:0] st_code;
        logic       pick_load;
        logic       res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       count_zero;
        logic       full;
        logic       gt;
        logic       match;
        logic       idx_one;
        logic       last;
        logic       found;
    } dp_sts_t;

endpackage

/* rtl/rmrq_dpath.sv */
// Datapath of the ready queue: slot memory, index and count registers, result word.
// Depends on rmrq_pkg; driven by rmrq_ctrl.
module rmrq_dpath import rmrq_pkg::*; #(
    parameter int QUEUE_DEPTH = RMRQ_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_word,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output out_word_t m_word
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    slot_t          mem [QUEUE_DEPTH];
    slot_t          rd_data_reg;
    in_word_t       req_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic           found_reg;
    logic [1:0]     status_reg;
    logic [15:0]    picked_reg;
    out_word_t      m_word_reg;
    logic [CW-1:0]  rd_ptr;
    logic [CW-1:0]  wr_ptr;
    slot_t          wr_data;
    slot_t          new_slot;

    always_comb begin
        unique case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_COUNT: idx_next = count_reg;
            IDX_INC:   idx_next = idx_reg + CW'(1);
            IDX_DEC:   idx_next = idx_reg - CW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign rd_ptr   = cmd.rd_dn ? (idx_next - CW'(1)) : idx_next;
    assign wr_ptr   = cmd.wr_dn ? (idx_reg - CW'(1)) : idx_reg;
    assign new_slot = '{period: req_reg.period, task_id: req_reg.task_id};
    assign wr_data  = cmd.wr_new ? new_slot : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_ptr[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.found_clr) begin
                found_reg <= 1'b0;
            end else if (cmd.found_set) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg    <= s_word;
            status_reg <= STAT_OK;
            picked_reg <= '0;
        end else begin
            if (cmd.st_load) begin
                status_reg <= cmd.st_code;
            end
            if (cmd.pick_load) begin
                picked_reg <= rd_data_reg.task_id;
            end
        end
        if (cmd.res_load) begin
            m_word_reg <= '{status: status_reg, picked_task: picked_reg,
                            queued_count: QC_W'(count_reg)};
        end
    end

    assign sts.action     = req_reg.action;
    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(QUEUE_DEPTH));
    assign sts.gt         = (rd_data_reg.period > req_reg.period);
    assign sts.match      = (rd_data_reg.task_id == req_reg.task_id);
    assign sts.idx_one    = (idx_reg == CW'(1));
    assign sts.last       = ((idx_reg + CW'(1)) == count_reg);
    assign sts.found      = found_reg;

    assign m_word = m_word_reg;

endmodule

/* rtl/rmrq_ctrl.sv */
// Controller state machine of the ready queue: sequences scans and shifts.
// Depends on rmrq_pkg; drives rmrq_dpath through dp_cmd_t.
module rmrq_ctrl import rmrq_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    m_ready,
    output logic    m_valid,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.action)
                    ACT_ENQ: begin
                        if (sts.full) begin
                            state_next = S_FIN;
                        end else if (sts.count_zero) begin
                            state_next = S_ENQ_PUT;
                        end else begin
                            state_next = S_ENQ_CMP;
                        end
                    end
                    ACT_DEQ: begin
                        state_next = sts.count_zero ? S_FIN : S_DEQ_CMP;
                    end
                    ACT_PICK: begin
                        state_next = sts.count_zero ? S_FIN : S_PICK_WAIT;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_ENQ_CMP: begin
                if (!sts.gt) begin
                    state_next = S_FIN;
                end else if (sts.idx_one) begin
                    state_next = S_ENQ_PUT;
                end
            end
            S_ENQ_PUT: begin
                state_next = S_FIN;
            end
            S_DEQ_CMP: begin
                if (sts.last) begin
                    state_next = S_FIN;
                end
            end
            S_PICK_WAIT: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.idx_op  = IDX_HOLD;
        cmd.st_code = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                cmd.req_load = s_valid;
            end
            S_DISPATCH: begin
                unique case (sts.action)
                    ACT_ENQ: begin
                        if (sts.full) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STAT_FULL;
                        end else begin
                            cmd.idx_op = IDX_COUNT;
                            cmd.rd_en  = !sts.count_zero;
                            cmd.rd_dn  = 1'b1;
                        end
                    end
                    ACT_DEQ: begin
                        if (sts.count_zero) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STAT_EMPTY;
                        end else begin
                            cmd.idx_op    = IDX_ZERO;
                            cmd.rd_en     = 1'b1;
                            cmd.found_clr = 1'b1;
                        end
                    end
                    ACT_PICK: begin
                        if (sts.count_zero) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STAT_EMPTY;
                        end else begin
                            cmd.idx_op = IDX_ZERO;
                            cmd.rd_en  = 1'b1;
                        end
                    end
                    default: begin
                        cmd.st_load = 1'b0;
                    end
                endcase
            end
            S_ENQ_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.gt) begin
                    cmd.idx_op = IDX_DEC;
                    cmd.rd_en  = !sts.idx_one;
                    cmd.rd_dn  = 1'b1;
                end else begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_ENQ_PUT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_DEQ_CMP: begin
                cmd.wr_en     = sts.found;
                cmd.wr_dn     = 1'b1;
                cmd.found_set = !sts.found && sts.match;
                if (!sts.last) begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                end else if (sts.found || sts.match) begin
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = STAT_NOT_FOUND;
                end
            end
            S_PICK_WAIT: begin
                cmd.pick_load = 1'b1;
            end
            S_FIN: begin
                cmd.res_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd.res_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* rtl/rate_monotonic_ready_queue_unit.sv */
// Rate-monotonic ready queue, top level. Depends on rmrq_pkg, rmrq_ctrl, rmrq_dpath.
// One word at a time; the result loads in S_FIN, reached from S_DISPATCH for full,
// empty, unused codes; via S_PICK_WAIT, S_ENQ_CMP/S_ENQ_PUT, S_DEQ_CMP otherwise.
// The next word is taken in the cycle after the result register loads; the slot
// memory's single read and write port per cycle sets the scan and shift rate.
// Reset clears count and control; slot memory is not cleared, stale slots unread.
module rate_monotonic_ready_queue_unit import rmrq_pkg::*; #(
    parameter int QUEUE_DEPTH = RMRQ_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rmrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    rmrq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_word  (m_word)
    );

endmodule

/* rtl/rmrq_checker.sv */
// Port-level checker for the ready queue, bound to the top level.
// Depends on rmrq_pkg and rate_monotonic_ready_queue_unit_assert.svh.
`include "rate_monotonic_ready_queue_unit_assert.svh"

module rmrq_checker import rmrq_pkg::*; #(
    parameter int QUEUE_DEPTH = RMRQ_DEPTH_DEF
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    localparam logic [QC_W-1:0] FULL_COUNT = QC_W'(QUEUE_DEPTH);

    logic in_accept;
    logic res_error;
    logic res_full;
    logic res_stall;

    assign in_accept = s_valid && s_ready;
    assign res_error = m_valid && (m_word.status != STAT_OK);
    assign res_full  = m_valid && (m_word.status == STAT_FULL);
    assign res_stall = m_valid && !m_ready;

    `RMRQ_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, in_accept, !s_ready)
    `RMRQ_ASSERT_NOW(a_pick_zero_on_error, aclk, aresetn, res_error, m_word.picked_task == 16'd0)
    `RMRQ_ASSERT_NOW(a_full_count, aclk, aresetn, res_full, m_word.queued_count == FULL_COUNT)
    `RMRQ_ASSERT_NXT(a_result_hold, aclk, aresetn, res_stall, m_valid && $stable(m_word))

endmodule

bind rate_monotonic_ready_queue_unit rmrq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rmrq_checker (.*);
